@@ hdl/xup_pkg.sv @@
// Shared types, constants and color math for the XRGB to UYVY frame packer.
package xup_pkg;

  // Coordinate register width and the fixed header field width
  localparam int COORD_BITS   = 12;
  localparam int HDR_BITS     = 12;
  localparam int COL_BITS     = COORD_BITS - 1;
  localparam int CFG_IDX_BITS = 2;

  // Byte sequencer: header 0..7, pixel data 8..11, trailer 12..19
  localparam int IDX_BITS = 5;
  localparam logic [IDX_BITS-1:0] IDX_HDR      = 5'd0;
  localparam logic [IDX_BITS-1:0] IDX_DATA     = 5'd8;
  localparam logic [IDX_BITS-1:0] IDX_DATA_END = 5'd11;
  localparam logic [IDX_BITS-1:0] IDX_TRL_END  = 5'd19;

  // Entry queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Stream marker bytes
  localparam logic [7:0] MARKER_BYTE  = 8'hff;
  localparam logic [7:0] HDR_TAG_BYTE = 8'h00;
  localparam logic [7:0] TRL_TAG_BYTE = 8'hc0;
  localparam logic [7:0] PAD_BYTE     = 8'h00;

  // Fixed-point coefficients, 16 fractional bits
  localparam logic [24:0] Y_OFS  = 25'(16 << 16);
  localparam logic [24:0] C_OFS  = 25'(128 << 16);
  localparam logic [24:0] Y_R    = 25'd16763;
  localparam logic [24:0] Y_G    = 25'd32904;
  localparam logic [24:0] Y_B    = 25'd6391;
  localparam logic [24:0] U_R    = 25'd9676;
  localparam logic [24:0] U_G    = 25'd18996;
  localparam logic [24:0] C_MAIN = 25'd28672;
  localparam logic [24:0] V_G    = 25'd24009;
  localparam logic [24:0] V_B    = 25'd4663;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } xup_yuv_t;

  // One classified pair as handed to the byte sequencer
  typedef struct packed {
    logic        hdr;
    logic        trl;
    logic [23:0] pos;
    logic [23:0] dim;
    logic [7:0]  u;
    logic [7:0]  y1;
    logic [7:0]  v;
    logic [7:0]  y2;
  } xup_entry_t;

  // Per-pixel luma and chroma; all sums stay positive and below 2^24
  function automatic xup_yuv_t rgb_to_yuv(input logic [23:0] px);
    logic [24:0] r, g, b, ys, us, vs;
    xup_yuv_t    res;
    r  = {17'd0, px[23:16]};
    g  = {17'd0, px[15:8]};
    b  = {17'd0, px[7:0]};
    ys = Y_OFS + Y_R * r + Y_G * g + Y_B * b;
    us = C_OFS + C_MAIN * b - U_R * r - U_G * g;
    vs = C_OFS + C_MAIN * r - V_G * g - V_B * b;
    res.y = ys[23:16];
    res.u = us[23:16];
    res.v = vs[23:16];
    return res;
  endfunction

endpackage

@@ hdl/xup_front.sv @@
// Front end: accepts pixel pairs, tracks frame position, converts color.
module xup_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [47:0]                  s_data_i,   // first_pixel, second_pixel
  input  logic [xup_pkg::COORD_BITS-1:0] rect_left_i,
  input  logic [xup_pkg::COORD_BITS-1:0] rect_top_i,
  input  logic [xup_pkg::COORD_BITS-1:0] rect_width_i,
  input  logic [xup_pkg::COORD_BITS-1:0] rect_height_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output xup_pkg::xup_entry_t          entry_o
);
  import xup_pkg::*;

  logic                  a_ready, b_ready, accept;
  logic                  a_valid_q, a_valid_d, b_valid_q, b_valid_d;
  logic [23:0]           a_pix1_q, a_pix2_q;
  logic                  a_hdr_q, a_trl_q, b_hdr_q, b_trl_q;
  logic [23:0]           a_pos_q, a_dim_q, b_pos_q, b_dim_q;
  xup_yuv_t              yuv1, yuv2, b_yuv1_q, b_yuv2_q;
  logic [COL_BITS-1:0]   col_q, col_d, pairs;
  logic [COORD_BITS-1:0] row_q, row_d, rows;
  logic                  open_q, open_d;
  logic [COL_BITS:0]     col_inc;
  logic [COORD_BITS:0]   row_inc;
  logic                  col_end, row_end, trl;
  logic [8:0]            u_sum, v_sum;

  // Two-stage pipe with a ready chain into the queue
  assign b_ready   = !b_valid_q || !q_full_i;
  assign a_ready   = !a_valid_q || b_ready;
  assign s_ready_o = a_ready;
  assign accept    = s_valid_i && a_ready;

  // Row and frame bookkeeping; degenerate sizes count as one
  always_comb begin
    pairs   = rect_width_i[COORD_BITS-1:1];
    rows    = rect_height_i;
    if (pairs == '0) pairs = COL_BITS'(1);
    if (rows == '0) rows = COORD_BITS'(1);
    col_inc = {1'b0, col_q} + (COL_BITS+1)'(1);
    row_inc = {1'b0, row_q} + (COORD_BITS+1)'(1);
    col_end = col_inc >= {1'b0, pairs};
    row_end = row_inc >= {1'b0, rows};
    trl     = col_end && row_end;
    col_d   = col_q;
    row_d   = row_q;
    open_d  = open_q;
    if (accept) begin
      open_d = !trl;
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_inc[COORD_BITS-1:0];
      end else begin
        col_d = col_inc[COL_BITS-1:0];
      end
    end
  end

  assign a_valid_d = a_ready ? s_valid_i : a_valid_q;
  assign b_valid_d = b_ready ? a_valid_q : b_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      open_q    <= 1'b0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      open_q    <= open_d;
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // Stage A: accepted pair plus its header snapshot
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix1_q <= s_data_i[23:0];
      a_pix2_q <= s_data_i[47:24];
      a_hdr_q  <= !open_q;
      a_trl_q  <= trl;
      a_pos_q  <= {HDR_BITS'(rect_left_i), HDR_BITS'(rect_top_i)};
      a_dim_q  <= {HDR_BITS'(rect_width_i), HDR_BITS'(rect_height_i)};
    end
  end

  // Stage B: per-pixel luma and chroma
  assign yuv1 = rgb_to_yuv(a_pix1_q);
  assign yuv2 = rgb_to_yuv(a_pix2_q);

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      b_yuv1_q <= yuv1;
      b_yuv2_q <= yuv2;
      b_hdr_q  <= a_hdr_q;
      b_trl_q  <= a_trl_q;
      b_pos_q  <= a_pos_q;
      b_dim_q  <= a_dim_q;
    end
  end

  // Chroma average on the way into the queue
  assign u_sum = {1'b0, b_yuv1_q.u} + {1'b0, b_yuv2_q.u};
  assign v_sum = {1'b0, b_yuv1_q.v} + {1'b0, b_yuv2_q.v};

  assign push_o     = b_valid_q && !q_full_i;
  assign entry_o.hdr = b_hdr_q;
  assign entry_o.trl = b_trl_q;
  assign entry_o.pos = b_pos_q;
  assign entry_o.dim = b_dim_q;
  assign entry_o.u   = u_sum[8:1];
  assign entry_o.y1  = b_yuv1_q.y;
  assign entry_o.v   = v_sum[8:1];
  assign entry_o.y2  = b_yuv2_q.y;

endmodule

@@ hdl/xup_queue.sv @@
// Short entry queue that decouples the front end from the byte sequencer.
module xup_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  xup_pkg::xup_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output xup_pkg::xup_entry_t head_o
);
  import xup_pkg::*;

  xup_entry_t      mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_AW:0]   count_q, count_d;

  assign full_o  = count_q == (Q_AW+1)'(Q_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + Q_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + Q_AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) count_d = count_q + (Q_AW+1)'(1);
    if (pop_i && !push_i) count_d = count_q - (Q_AW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");

endmodule

@@ hdl/xup_back.sv @@
// Back end: walks each queued pair through header, UYVY and trailer bytes.
module xup_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  xup_pkg::xup_entry_t head_i,
  output logic                pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [7:0]          m_byte_o,
  output logic                m_last_o,
  output logic                m_done_o
);
  import xup_pkg::*;

  logic                active_q, active_d;
  logic [IDX_BITS-1:0] idx_q, idx_d, cur_idx, end_idx;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, sel_byte;
  logic                out_last_q, out_done_q;
  logic                emit, is_last;

  // Current byte position of the head entry
  assign cur_idx = active_q ? idx_q : (head_i.hdr ? IDX_HDR : IDX_DATA);
  assign end_idx = head_i.trl ? IDX_TRL_END : IDX_DATA_END;
  assign is_last = cur_idx == end_idx;
  assign emit    = q_valid_i && (!out_valid_q || m_ready_i);
  assign pop_o   = emit && is_last;

  // Byte selection by position
  always_comb begin
    case (cur_idx)
      5'd0:    sel_byte = MARKER_BYTE;
      5'd1:    sel_byte = HDR_TAG_BYTE;
      5'd2:    sel_byte = head_i.pos[23:16];
      5'd3:    sel_byte = head_i.pos[15:8];
      5'd4:    sel_byte = head_i.pos[7:0];
      5'd5:    sel_byte = head_i.dim[23:16];
      5'd6:    sel_byte = head_i.dim[15:8];
      5'd7:    sel_byte = head_i.dim[7:0];
      5'd8:    sel_byte = head_i.u;
      5'd9:    sel_byte = head_i.y1;
      5'd10:   sel_byte = head_i.v;
      5'd11:   sel_byte = head_i.y2;
      5'd12:   sel_byte = MARKER_BYTE;
      5'd13:   sel_byte = TRL_TAG_BYTE;
      default: sel_byte = PAD_BYTE;
    endcase
  end

  // Sequencer and output register control
  always_comb begin
    active_d    = active_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_ready_i) out_valid_d = 1'b0;
    if (emit) begin
      out_valid_d = 1'b1;
      active_d    = !is_last;
      idx_d       = cur_idx + IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= sel_byte;
      out_last_q <= is_last;
      out_done_q <= is_last && head_i.trl;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_byte_o  = out_byte_q;
  assign m_last_o  = out_last_q;
  assign m_done_o  = out_done_q;

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && m_done_o |-> m_last_o)
    else $error("frame end not on a run end");

  a_entry_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> q_valid_i)
    else $error("entry left the queue mid-sequence");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> cur_idx <= IDX_TRL_END)
    else $error("byte position out of range");

endmodule

@@ hdl/xrgb_to_uyvy_frame_packer_unit.sv @@
// Top level of the XRGB to UYVY frame packer: config registers and wiring.
// Takes one pixel pair per beat and sends one byte per beat: U, Y1, V, Y2 for
// each pair, an 8-byte header before the first pair of a frame and an 8-byte
// trailer after the last, so the byte-wide output register, not the input,
// sets the pace of a steady stream. A pair passes front stages A and B and the
// queue before the output register, and the 4-entry queue lets the input keep
// flowing while the output is stalled, until the queue fills.
// Rectangle registers are written through the cfg port; the user must do so only
// while the unit is idle, as the block itself does not enforce it.
module xrgb_to_uyvy_frame_packer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [47:0]                       s_axis_tdata_i,  // first_pixel, second_pixel
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,  // out_byte
  output logic                              m_axis_tlast_o,  // run_last
  output logic                              m_axis_tuser_o,  // frame_done
  input  logic                              cfg_we_i,
  input  logic [xup_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [xup_pkg::COORD_BITS-1:0]    cfg_data_i
);
  import xup_pkg::*;

  logic [COORD_BITS-1:0] left_q, top_q, width_q, height_q;
  logic                  q_full, q_push, q_pop, q_valid;
  xup_entry_t            q_entry, q_head;

  // Rectangle registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= COORD_BITS'(2);
      height_q <= COORD_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_LEFT:   left_q   <= cfg_data_i;
        CFG_TOP:    top_q    <= cfg_data_i;
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  xup_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid_i),
    .s_ready_o     (s_axis_tready_o),
    .s_data_i      (s_axis_tdata_i),
    .rect_left_i   (left_q),
    .rect_top_i    (top_q),
    .rect_width_i  (width_q),
    .rect_height_i (height_q),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .entry_o       (q_entry)
  );

  xup_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  xup_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (q_head),
    .pop_o     (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_byte_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o),
    .m_done_o  (m_axis_tuser_o)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Stream-level testbench for the XRGB to UYVY frame packer: random pixel pairs, checked byte-wise.
module testbench;
  import xup_pkg::*;

  // One expected output beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } out_beat_t;

  // Predicts the byte stream of each accepted pair and checks the output against it
  class uyvy_stream_checker;
    logic [COORD_BITS-1:0] left, top, width, height;
    logic [COL_BITS-1:0]   col;
    logic [COORD_BITS-1:0] row;
    bit                    frame_open;
    out_beat_t             pending_bytes[$];
    int                    errors;

    function new();
      left       = '0;
      top        = '0;
      width      = 12'd2;
      height     = 12'd1;
      col        = '0;
      row        = '0;
      frame_open = 1'b0;
      errors     = 0;
    endfunction

    // Fixed-point color terms, 16 fractional bits, floored
    function int unsigned y_level(logic [23:0] px);
      int unsigned r, g, b;
      r = 32'(px[23:16]);
      g = 32'(px[15:8]);
      b = 32'(px[7:0]);
      return ((16 << 16) + 16763 * r + 32904 * g + 6391 * b) >> 16;
    endfunction

    function int unsigned blue_diff(logic [23:0] px);
      int unsigned r, g, b;
      r = 32'(px[23:16]);
      g = 32'(px[15:8]);
      b = 32'(px[7:0]);
      return ((128 << 16) + 28672 * b - 9676 * r - 18996 * g) >> 16;
    endfunction

    function int unsigned red_diff(logic [23:0] px);
      int unsigned r, g, b;
      r = 32'(px[23:16]);
      g = 32'(px[15:8]);
      b = 32'(px[7:0]);
      return ((128 << 16) + 28672 * r - 24009 * g - 4663 * b) >> 16;
    endfunction

    function int unsigned pairs_per_row();
      return (width >> 1) == 0 ? 1 : (width >> 1);
    endfunction

    function int unsigned rows_per_frame();
      return height == 0 ? 1 : height;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [COORD_BITS-1:0] val);
      case (idx)
        CFG_LEFT:   left = val;
        CFG_TOP:    top = val;
        CFG_WIDTH:  width = val;
        CFG_HEIGHT: height = val;
        default: ;
      endcase
    endfunction

    // Pairs still needed to close the open frame under the current rectangle
    function int unsigned remaining_pairs();
      int unsigned p, r, in_row;
      p = pairs_per_row();
      r = rows_per_frame();
      in_row = (col + 1 >= p) ? 1 : p - col;
      if (row + 1 >= r) return in_row;
      return in_row + (r - row - 1) * p;
    endfunction

    // Accepted pair: header if the frame is new, UYVY bytes, trailer on frame end
    function void take_pair(logic [47:0] d);
      logic [23:0]  p1, p2, pos, dim;
      logic [7:0]   seq [20];
      int unsigned  u, v;
      int           n;
      bit           done;
      out_beat_t    beat;
      p1   = d[23:0];
      p2   = d[47:24];
      pos  = {left, top};
      dim  = {width, height};
      n    = 0;
      done = 1'b0;
      if (!frame_open) begin
        seq[0] = MARKER_BYTE;
        seq[1] = HDR_TAG_BYTE;
        seq[2] = pos[23:16];
        seq[3] = pos[15:8];
        seq[4] = pos[7:0];
        seq[5] = dim[23:16];
        seq[6] = dim[15:8];
        seq[7] = dim[7:0];
        n = 8;
        frame_open = 1'b1;
      end
      u = (blue_diff(p1) + blue_diff(p2)) >> 1;
      v = (red_diff(p1) + red_diff(p2)) >> 1;
      seq[n]     = 8'(u);
      seq[n + 1] = 8'(y_level(p1));
      seq[n + 2] = 8'(v);
      seq[n + 3] = 8'(y_level(p2));
      n = n + 4;
      // Row and frame end test with the registers as they stand now
      if (col + 1 >= pairs_per_row()) begin
        col = '0;
        if (row + 1 >= rows_per_frame()) begin
          seq[n] = MARKER_BYTE;
          seq[n + 1] = TRL_TAG_BYTE;
          for (int i = 2; i < 8; i++) seq[n + i] = PAD_BYTE;
          n = n + 8;
          done = 1'b1;
          row = '0;
          frame_open = 1'b0;
        end else begin
          row = row + 1'b1;
        end
      end else begin
        col = col + 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        beat.data = seq[i];
        beat.last = (i == n - 1);
        beat.done = done && (i == n - 1);
        pending_bytes.push_back(beat);
      end
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_byte(logic [7:0] data, logic last, logic done);
      out_beat_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("byte %02h with nothing expected", data));
        return;
      end
      want = pending_bytes.pop_front();
      if (data !== want.data)
        report($sformatf("out_byte %02h, expected %02h", data, want.data));
      if (last !== want.last)
        report($sformatf("run_last %b, expected %b (byte %02h)", last, want.last, want.data));
      if (done !== want.done)
        report($sformatf("frame_done %b, expected %b (byte %02h)", done, want.done, want.data));
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  logic [47:0]             s_axis_tdata_i;   // first_pixel, second_pixel
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  logic [7:0]              m_axis_tdata_o;   // out_byte
  logic                    m_axis_tlast_o;   // run_last
  logic                    m_axis_tuser_o;   // frame_done
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [COORD_BITS-1:0]   cfg_data_i;

  uyvy_stream_checker sb = new();
  bit                 no_gaps = 1'b0;

  xrgb_to_uyvy_frame_packer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Output side stalls at random, except in the gap-free window
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= no_gaps || ($urandom_range(99) >= 36);
    end
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.take_pair(s_axis_tdata_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_byte(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
  end

  // Hard stop
  initial begin
    #5000000;
    $display("[xrgb_to_uyvy_frame_packer_unit] ERROR");
    $finish;
  end

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hffffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // Present one pair from a falling edge, hold until accepted; returns at a falling edge
  task automatic send_pair(input logic [23:0] first_px, input logic [23:0] second_px);
    while (!no_gaps && $urandom_range(99) < 36) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {second_px, first_px};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Let the stream drain, then write all four rectangle registers
  task automatic set_rect(input logic [11:0] l, input logic [11:0] t,
                          input logic [11:0] w, input logic [11:0] h);
    cfg_reg_e    regs [4];
    logic [11:0] vals [4];
    regs = '{CFG_LEFT, CFG_TOP, CFG_WIDTH, CFG_HEIGHT};
    vals = '{l, t, w, h};
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      sb.set_reg(regs[i], vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int          sent;
    int unsigned count;
    bit          big;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_LEFT;
    cfg_data_i      = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset rectangle: one-pair frames, header and trailer around each pair
    send_pair(24'h000000, 24'hffffff);
    send_pair(24'hffffff, 24'h000000);

    // Extreme position, two rows of two pairs, primary colors
    set_rect(12'd4094, 12'd4095, 12'd4, 12'd2);
    send_pair(24'hff0000, 24'h00ff00);
    send_pair(24'h0000ff, 24'hff00ff);
    send_pair(24'h00ffff, 24'hffff00);
    send_pair(24'h808080, 24'h7f7f7f);

    // Zero width and zero height: a single pair per frame
    set_rect(12'd1, 12'd0, 12'd0, 12'd0);
    send_pair(24'h123456, 24'hfedcba);

    // Width one: one pair per row, three rows
    set_rect(12'haaa, 12'h555, 12'd1, 12'd3);
    send_pair(24'hff0000, 24'h0000ff);
    send_pair(24'h00ff00, 24'hff00ff);
    send_pair(24'h000000, 24'h000000);

    // Odd width: three pairs per row, two rows
    set_rect(12'h555, 12'haaa, 12'd7, 12'd2);
    repeat (6) send_pair(rand_pixel(), rand_pixel());

    // Largest rectangle, then shrink mid-frame so the column is past the row end
    set_rect(12'h000, 12'h000, 12'd4095, 12'd4095);
    send_pair(24'hffffff, 24'hffffff);
    send_pair(24'h000000, 24'h000000);
    set_rect(12'hfff, 12'hfff, 12'd2, 12'd1);
    send_pair(24'h5a5a5a, 24'ha5a5a5);

    // Random frames; mostly complete ones, some cut short by a new rectangle
    sent = 0;
    while (sent < 90) begin
      no_gaps = (sent >= 30 && sent < 60);
      big = ($urandom_range(7) == 0);
      set_rect(12'($urandom), 12'($urandom),
               big ? 12'($urandom) : 12'($urandom_range(10)),
               big ? 12'($urandom) : 12'($urandom_range(3)));
      count = sb.remaining_pairs();
      if ($urandom_range(3) == 0 || count > 16) count = $urandom_range(1, 6);
      repeat (count) begin
        send_pair(rand_pixel(), rand_pixel());
        sent++;
      end
    end
    no_gaps = 1'b0;

    // Wait out the remaining bytes
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("[xrgb_to_uyvy_frame_packer_unit] OK");
    else
      $display("[xrgb_to_uyvy_frame_packer_unit] ERROR");
    $finish;
  end

endmodule
